// File: design/sponge_layer_damping_source_macros.svh
// Assertion macros for the sponge layer damping source.
// Used by the top level only; expects clk and arst_n in scope.
`ifndef SPONGE_LAYER_DAMPING_SOURCE_MACROS_SVH
`define SPONGE_LAYER_DAMPING_SOURCE_MACROS_SVH

// Same-cycle implication, disabled during reset
`define SLDS_ASSERT_NOW(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// Next-cycle implication, disabled during reset
`define SLDS_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

// File: design/slds_pkg.sv
// Package for the sponge layer damping source: widths, codes and the
// sine-squared node table built at elaboration. No dependencies.
package slds_pkg;

	localparam int TRIG_TABLE_BITS = 10;
	localparam int TRIG_N          = 1 << TRIG_TABLE_BITS;
	localparam int TRIG_IDX_W      = TRIG_TABLE_BITS + 1;
	localparam int INTERP_SHIFT    = 16 - TRIG_TABLE_BITS;

	localparam logic [16:0] ONE16 = 17'd65536;
	localparam int DIV_STEPS = 16;

	localparam longint unsigned ONE30  = 64'd1 << 30;
	localparam longint unsigned PI_Q30 = 64'd3373259426;
	localparam longint unsigned TAYLOR_DIV [0:4] = '{64'd132, 64'd90, 64'd56, 64'd30, 64'd12};

	// configuration register indexes
	typedef enum logic [2:0] {
		REG_THICKNESS = 3'd0,
		REG_BLEND_FRAC = 3'd1,
		REG_BLEND_SHAPE = 3'd2,
		REG_INV_TAU = 3'd3,
		REG_REFERENCE = 3'd4,
		REG_DAMP_EN = 3'd5
	} cfg_reg_t;

	// falloff shapes
	localparam logic [2:0] SHAPE_SINSQ = 3'd1;
	localparam logic [2:0] SHAPE_LINEAR = 3'd2;
	localparam logic [2:0] SHAPE_QUAD = 3'd3;
	localparam logic [2:0] SHAPE_COSINE = 3'd4;

	typedef logic [16:0] sinsq_tab_t [0:TRIG_N];

	// fields that ride along the whole pipeline
	typedef struct packed {
		logic        inl;
		logic        full;
		logic        neg;
		logic [31:0] adiff;
		logic [31:0] ps;
		logic [31:0] pmag;
		logic [16:0] pst;
		logic [16:0] strength;
	} ctx_t;

	// sin^2 nodes, Q1.16, from a truncated Taylor cosine in Q30
	function automatic sinsq_tab_t sinsq_build();
		sinsq_tab_t tab;
		longint unsigned kk, t, t2, p, h, s30, s16;
		logic folded;
		for (int k = 0; k <= TRIG_N; k++) begin
			folded = (k > TRIG_N / 2);
			kk = folded ? 64'(TRIG_N - k) : 64'(k);
			t = (PI_Q30 * kk) >> TRIG_TABLE_BITS;
			t2 = (t * t) >> 30;
			p = ONE30;
			for (int i = 0; i < 5; i++) begin
				p = ONE30 - ((t2 * p) >> 30) / TAYLOR_DIV[i];
			end
			h = (t2 * p) >> 31;
			if (h > ONE30) begin
				h = ONE30;
			end
			s30 = folded ? ONE30 - (h >> 1) : (h >> 1);
			s16 = (s30 + (64'd1 << 13)) >> 14;
			if (s16 > 64'd65536) begin
				s16 = 64'd65536;
			end
			tab[k] = s16[16:0];
		end
		return tab;
	endfunction

endpackage

// File: design/sponge_layer_damping_source.sv
// Sponge layer damping source: per-cell Rayleigh damping strength and source.
// Depends on slds_pkg and sponge_layer_damping_source_macros.svh.
//
//  channel | dir | fields (low bit up)
//  s_*     | in  | distance 32, field_value 32, prior_source 32, prior_strength 17
//  m_*     | out | in_layer 1, strength 17, source 32, strength_max 17
//  cfg_*   | in  | write enable, 3-bit register index, 32-bit data
//
// One cell per cycle while the output is not stalled; the pipeline depth is set by the
// 16-stage restoring divider for the blend fraction plus table, gain and source stages.
// Reset clears valid bits and restores register defaults; no clearing pass.
// A stall at the output freezes every stage; nothing is dropped or repeated.
`include "sponge_layer_damping_source_macros.svh"

module sponge_layer_damping_source import slds_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// distance[31:0], field_value[63:32], prior_source[95:64], prior_strength[112:96]
	input  logic [119:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// in_layer[0], strength[17:1], source[49:18], strength_max[66:50]
	output logic [71:0]  m_tdata,
	input  logic         cfg_we,
	input  logic [2:0]   cfg_index,
	input  logic [31:0]  cfg_data
);

	localparam int LAST = 24;
	localparam int STR_ST = 21;
	localparam logic [TRIG_IDX_W-1:0] TRIG_LAST = TRIG_IDX_W'(TRIG_N);

	localparam sinsq_tab_t SINSQ_TAB = sinsq_build();

	// configuration registers
	logic [30:0] thick_q;
	logic [16:0] bfrac_q;
	logic [2:0]  shape_q;
	logic [30:0] inv_tau_q;
	logic [31:0] ref_q;
	logic        damp_en_q;
	logic [30:0] dfull_q;
	logic [30:0] dblend_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thick_q <= '0;
			bfrac_q <= ONE16;
			shape_q <= '0;
			inv_tau_q <= '0;
			ref_q <= '0;
			damp_en_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_THICKNESS: thick_q <= cfg_data[30:0];
				REG_BLEND_FRAC: bfrac_q <= cfg_data[16:0];
				REG_BLEND_SHAPE: shape_q <= cfg_data[2:0];
				REG_INV_TAU: inv_tau_q <= cfg_data[30:0];
				REG_REFERENCE: ref_q <= cfg_data;
				REG_DAMP_EN: damp_en_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// full-depth and blended depths, refreshed from the registers each cycle
	logic [16:0] bf_sat;
	logic [47:0] dfull_prod;
	logic [47:0] dblend_prod;
	assign bf_sat = (bfrac_q > ONE16) ? ONE16 : bfrac_q;
	assign dfull_prod = 48'(ONE16 - bf_sat) * 48'(thick_q);
	assign dblend_prod = 48'(bf_sat) * 48'(thick_q);

	always_ff @(posedge clk) begin
		dfull_q <= dfull_prod[46:16];
		dblend_q <= (dblend_prod[46:16] == '0) ? 31'd1 : dblend_prod[46:16];
	end

	// pipeline control: all stages move together
	logic adv;
	logic vld_s [0:LAST];
	ctx_t ctx_s [0:LAST];
	assign adv = !vld_s[LAST] || m_tready;
	assign s_tready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= LAST; i++) begin
				vld_s[i] <= 1'b0;
			end
		end else if (adv) begin
			vld_s[0] <= s_tvalid;
			for (int i = 1; i <= LAST; i++) begin
				vld_s[i] <= vld_s[i-1];
			end
		end
	end

	// stage 0: unpack, saturate prior strength, reference difference
	logic [31:0] in_d, in_fv, in_ps;
	logic [16:0] in_pst;
	logic [32:0] diff;
	ctx_t        ctx_in;
	logic [31:0] d_s0;
	assign in_d = s_tdata[31:0];
	assign in_fv = s_tdata[63:32];
	assign in_ps = s_tdata[95:64];
	assign in_pst = s_tdata[112:96];
	assign diff = {ref_q[31], ref_q} - {in_fv[31], in_fv};

	always_comb begin
		ctx_in = '0;
		ctx_in.neg = diff[32];
		ctx_in.adiff = diff[32] ? 32'(-diff) : diff[31:0];
		ctx_in.ps = in_ps;
		ctx_in.pmag = in_ps[31] ? (32'd0 - in_ps) : in_ps;
		ctx_in.pst = (in_pst > ONE16) ? ONE16 : in_pst;
	end

	// stage 1: layer test and offset into the blended part
	logic [30:0] a_s1;
	logic        inl_nxt, full_nxt;
	assign inl_nxt = !d_s0[31] && (d_s0[30:0] <= thick_q);
	assign full_nxt = d_s0[30:0] < dfull_q;

	// divider stages (index i sits at stage 2 + i)
	logic [30:0] dv_rem_s [0:DIV_STEPS];
	logic [15:0] dv_q_s   [0:DIV_STEPS];
	logic        dv_ge_s  [0:DIV_STEPS];
	logic [32:0] dv_sub   [1:DIV_STEPS];

	always_comb begin
		for (int i = 1; i <= DIV_STEPS; i++) begin
			dv_sub[i] = {1'b0, dv_rem_s[i-1], 1'b0} - {2'b00, dblend_q};
		end
	end

	// stage 19: fraction clamp and complement
	logic [16:0] u_s19;
	logic [16:0] f_nxt;
	assign f_nxt = dv_ge_s[DIV_STEPS] ? ONE16 : {1'b0, dv_q_s[DIV_STEPS]};

	// stage 20: table nodes, quadratic
	logic [TRIG_IDX_W-1:0] k0, k1;
	logic [33:0]           uu;
	logic [16:0]           s0_s20, s1_s20, u_s20, quad_s20;
	logic [INTERP_SHIFT-1:0] fr_s20;
	assign k0 = u_s19[16:INTERP_SHIFT];
	assign k1 = (k0 == TRIG_LAST) ? k0 : k0 + 1'b1;
	assign uu = 34'(u_s19) * 34'(u_s19) + 34'd32768;

	// stage 21: interpolation and shape select
	logic [16:0] node_dlt;
	logic [16+INTERP_SHIFT:0] node_step;
	logic [16:0] sinsq_val;
	logic [16:0] str_nxt;
	assign node_dlt = (s1_s20 >= s0_s20) ? (s1_s20 - s0_s20) : (s0_s20 - s1_s20);
	assign node_step = (17+INTERP_SHIFT)'(node_dlt) * (17+INTERP_SHIFT)'(fr_s20);

	always_comb begin
		if (s1_s20 >= s0_s20) begin
			sinsq_val = s0_s20 + node_step[16+INTERP_SHIFT:INTERP_SHIFT];
		end else begin
			sinsq_val = s0_s20 - node_step[16+INTERP_SHIFT:INTERP_SHIFT];
		end
		if (sinsq_val > ONE16) begin
			sinsq_val = ONE16;
		end
	end

	always_comb begin
		if (!ctx_s[20].inl) begin
			str_nxt = '0;
		end else if (ctx_s[20].full) begin
			str_nxt = ONE16;
		end else begin
			unique case (shape_q)
				SHAPE_SINSQ, SHAPE_COSINE: str_nxt = sinsq_val;
				SHAPE_LINEAR: str_nxt = u_s20;
				SHAPE_QUAD: str_nxt = quad_s20;
				default: str_nxt = '0;
			endcase
		end
	end

	// context entering stage 1 and the strength stage, with their new fields
	ctx_t ctx_s1_nxt, ctx_str_nxt;
	always_comb begin
		ctx_s1_nxt = ctx_s[0];
		ctx_s1_nxt.inl = inl_nxt;
		ctx_s1_nxt.full = full_nxt;
		ctx_str_nxt = ctx_s[STR_ST-1];
		ctx_str_nxt.strength = str_nxt;
	end

	// stage 22: gain, stage 23: source magnitude
	logic [47:0] gain_prod;
	logic [30:0] g_s22;
	logic [62:0] mag_prod;
	logic [46:0] nraw_s23;
	assign gain_prod = 48'(inv_tau_q) * 48'(ctx_s[STR_ST].strength) + 48'd32768;
	assign mag_prod = 63'(g_s22) * 63'(ctx_s[22].adiff) + 63'd32768;

	// stage 24: saturate, pick larger source and strength
	logic [46:0] lim;
	logic [31:0] nmag;
	logic [31:0] src_nxt;
	logic [31:0] src_s24;
	logic [16:0] smax_s24;
	assign lim = ctx_s[23].neg ? 47'h0_8000_0000 : 47'h0_7FFF_FFFF;
	assign nmag = (nraw_s23 > lim) ? lim[31:0] : nraw_s23[31:0];
	assign src_nxt = (damp_en_q && ctx_s[23].inl && (nmag > ctx_s[23].pmag)) ?
		(ctx_s[23].neg ? (32'd0 - nmag) : nmag) : ctx_s[23].ps;

	// payload registers
	always_ff @(posedge clk) begin
		if (adv) begin
			ctx_s[0] <= ctx_in;
			d_s0 <= in_d;
			ctx_s[1] <= ctx_s1_nxt;
			for (int i = 2; i <= LAST; i++) begin
				if (i == STR_ST) begin
					ctx_s[i] <= ctx_str_nxt;
				end else begin
					ctx_s[i] <= ctx_s[i-1];
				end
			end
			a_s1 <= d_s0[30:0] - dfull_q;
			// divider start
			dv_ge_s[0] <= a_s1 >= dblend_q;
			dv_rem_s[0] <= a_s1;
			dv_q_s[0] <= '0;
			// one quotient bit per stage
			for (int i = 1; i <= DIV_STEPS; i++) begin
				dv_ge_s[i] <= dv_ge_s[i-1];
				if (!dv_sub[i][32]) begin
					dv_rem_s[i] <= dv_sub[i][30:0];
					dv_q_s[i] <= {dv_q_s[i-1][14:0], 1'b1};
				end else begin
					dv_rem_s[i] <= {dv_rem_s[i-1][29:0], 1'b0};
					dv_q_s[i] <= {dv_q_s[i-1][14:0], 1'b0};
				end
			end
			u_s19 <= ONE16 - f_nxt;
			s0_s20 <= SINSQ_TAB[k0];
			s1_s20 <= SINSQ_TAB[k1];
			u_s20 <= u_s19;
			fr_s20 <= u_s19[INTERP_SHIFT-1:0];
			quad_s20 <= uu[32:16];
			g_s22 <= gain_prod[46:16];
			nraw_s23 <= mag_prod[62:16];
			src_s24 <= src_nxt;
			smax_s24 <= (ctx_s[23].strength > ctx_s[23].pst) ?
				ctx_s[23].strength : ctx_s[23].pst;
		end
	end

	assign m_tvalid = vld_s[LAST];
	assign m_tdata = {5'b0, smax_s24, src_s24, ctx_s[LAST].strength, ctx_s[LAST].inl};

	// checks
	`SLDS_ASSERT_NOW(a_out_layer, m_tvalid && !m_tdata[0], m_tdata[17:1] == '0,
		"strength nonzero outside the layer")
	`SLDS_ASSERT_NOW(a_smax, m_tvalid, m_tdata[66:50] >= m_tdata[17:1],
		"strength_max below strength")
	`SLDS_ASSERT_NOW(a_div_rem, vld_s[18] && !dv_ge_s[DIV_STEPS],
		dv_rem_s[DIV_STEPS] < dblend_q, "divider remainder out of range")
	`SLDS_ASSERT_NEXT(a_advance, vld_s[LAST-1] && adv, m_tvalid,
		"pipeline lost an item at the output stage")

endmodule
